@@ rtl/template_pixel_match_and_learn_top_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef TEMPLATE_PIXEL_MATCH_AND_LEARN_TOP_MACROS_SVH
`define TEMPLATE_PIXEL_MATCH_AND_LEARN_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TPML_AST_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TPML_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPML_AST_IMPL(lbl, ante, cons, msg)
`define TPML_AST_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/tpml_pkg.sv @@
`default_nettype none

package tpml_pkg;

    localparam int MAX_PIXELS = 4096;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int POS_W      = ADDR_W + 1;
    localparam int PIX_W      = 8;
    localparam int LVL_W      = PIX_W + 1;
    localparam int CNT_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_PIXELS);
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_MATCH = 2'd1;
    localparam logic [1:0] CMD_LEARN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_LVL  = 2'd2;

    localparam logic [CNT_W-1:0] RST_PIXEL_COUNT = 13'd1024;
    localparam logic [LVL_W-1:0] RST_MATCH_TOL   = 9'd120;
    localparam logic [LVL_W-1:0] RST_IGNORE_LVL  = 9'd250;

    typedef struct packed {
        logic             wr_en;
        logic [PIX_W-1:0] wr_data;
        logic             hit;
    } t_eval;

endpackage

`default_nettype wire

@@ rtl/template_pixel_match_and_learn_top.sv @@
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------
// pixel in | i_valid / o_stall   | i_cmd, i_pixel, i_frame_end
// result   | o_valid / i_stall   | o_match_count, o_size_error
// config   | i_cfg_we            | i_cfg_index, i_cfg_data
//
// One item per cycle while o_stall is low. The template RAM is read when an
// item is taken and written from the compute stage when the item leaves it;
// a same-address bypass covers a one-pixel frame followed by a new frame.
// A result is registered once its frame_end item leaves the compute stage.
// Synchronous active-low reset restores the register defaults, not the template.
// o_stall rises only when a frame_end item meets a full, stalled result register.
`default_nettype none

`include "template_pixel_match_and_learn_top_macros.svh"

module template_pixel_match_and_learn_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tpml_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tpml_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_valid,
    output      logic                            o_stall,
    input  wire logic [1:0]                      i_cmd,
    input  wire logic [tpml_pkg::PIX_W-1:0]      i_pixel,
    input  wire logic                            i_frame_end,
    output      logic                            o_valid,
    input  wire logic                            i_stall,
    output      logic [tpml_pkg::CNT_W-1:0]      o_match_count,
    output      logic                            o_size_error
);

    localparam int AW = tpml_pkg::ADDR_W;
    localparam int PW = tpml_pkg::POS_W;
    localparam int XW = tpml_pkg::PIX_W;
    localparam int CW = tpml_pkg::CNT_W;
    localparam int LW = tpml_pkg::LVL_W;

    logic [CW-1:0] r_pixel_count;
    logic [LW-1:0] r_match_tol;
    logic [LW-1:0] r_ignore_lvl;

    logic [XW-1:0] r_mem [tpml_pkg::MAX_PIXELS];
    logic [XW-1:0] r_q;

    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;

    logic          r_s1_valid;
    logic [1:0]    r_s1_cmd;
    logic [XW-1:0] r_s1_pixel;
    logic          r_s1_last;
    logic [PW-1:0] r_s1_pos;
    logic          r_byp;
    logic [XW-1:0] r_byp_data;

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_ovf;
    logic          n_ovf;

    logic          r_out_valid;
    logic [CW-1:0] r_out_count;
    logic          r_out_err;

    logic            accept;
    logic            s1_go;
    logic            in_range;
    logic [XW-1:0]   tmpl;
    logic [PW-1:0]   length;
    tpml_pkg::t_eval eval;

    assign s1_go   = r_s1_valid && !(r_s1_last && r_out_valid && i_stall);
    assign o_stall = r_s1_valid && !s1_go;
    assign accept  = i_valid && !o_stall;

    assign in_range = (r_s1_pos < tpml_pkg::POS_MAX) && (r_s1_pos < r_pixel_count);
    assign tmpl     = r_byp ? r_byp_data : r_q;
    assign length   = r_s1_pos + PW'(1);

    tpml_eval u_eval (
        .i_cmd      (r_s1_cmd),
        .i_pixel    (r_s1_pixel),
        .i_tmpl     (tmpl),
        .i_tol      (r_match_tol),
        .i_ign      (r_ignore_lvl),
        .i_in_range (in_range),
        .o_eval     (eval)
    );

    always_comb begin
        n_cnt = r_cnt;
        if (eval.hit && (r_cnt != tpml_pkg::COUNT_MAX)) begin
            n_cnt = r_cnt + CW'(1);
        end
        n_ovf = r_ovf || !in_range;
        n_pos = r_pos;
        if (i_frame_end) begin
            n_pos = '0;
        end else if (r_pos < tpml_pkg::POS_MAX) begin
            n_pos = r_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= tpml_pkg::RST_PIXEL_COUNT;
            r_match_tol   <= tpml_pkg::RST_MATCH_TOL;
            r_ignore_lvl  <= tpml_pkg::RST_IGNORE_LVL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tpml_pkg::REG_PIXEL_COUNT: r_pixel_count <= i_cfg_data;
                tpml_pkg::REG_MATCH_TOL:   r_match_tol   <= i_cfg_data[LW-1:0];
                tpml_pkg::REG_IGNORE_LVL:  r_ignore_lvl  <= i_cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && eval.wr_en) begin
            r_mem[r_s1_pos[AW-1:0]] <= eval.wr_data;
        end
        if (accept) begin
            r_q <= r_mem[r_pos[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd   <= i_cmd;
            r_s1_pixel <= i_pixel;
            r_s1_last  <= i_frame_end;
            r_s1_pos   <= r_pos;
            r_byp      <= s1_go && eval.wr_en && (r_s1_pos[AW-1:0] == r_pos[AW-1:0]);
            r_byp_data <= eval.wr_data;
        end
        if (s1_go && r_s1_last) begin
            r_out_count <= n_cnt;
            r_out_err   <= n_ovf || (length != r_pixel_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos <= n_pos;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_cnt <= r_s1_last ? '0 : n_cnt;
                r_ovf <= r_s1_last ? 1'b0 : n_ovf;
            end
            if (s1_go && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_match_count = r_out_count;
    assign o_size_error  = r_out_err;

    `TPML_AST_IMPL(a_stall_cause, o_stall, r_s1_last && r_out_valid && i_stall, "bad stall")
    `TPML_AST_IMPL(a_pos_bound, 1'b1, r_pos <= tpml_pkg::POS_MAX, "position overrun")
    `TPML_AST_NEXT(a_frame_clear, s1_go && r_s1_last, (r_cnt == '0) && !r_ovf, "frame not cleared")
    `TPML_AST_NEXT(a_result_out, s1_go && r_s1_last, r_out_valid, "result lost")

endmodule

`default_nettype wire

@@ rtl/tpml_eval.sv @@
`default_nettype none

module tpml_eval (
    input  wire logic [1:0]                 i_cmd,
    input  wire logic [tpml_pkg::PIX_W-1:0] i_pixel,
    input  wire logic [tpml_pkg::PIX_W-1:0] i_tmpl,
    input  wire logic [tpml_pkg::LVL_W-1:0] i_tol,
    input  wire logic [tpml_pkg::LVL_W-1:0] i_ign,
    input  wire logic                       i_in_range,
    output tpml_pkg::t_eval                 o_eval
);

    logic [tpml_pkg::PIX_W-1:0] diff;
    logic [tpml_pkg::PIX_W:0]   sum_a;
    logic [tpml_pkg::PIX_W:0]   sum_b;
    logic                       below_ign;

    assign diff      = (i_pixel > i_tmpl) ? (i_pixel - i_tmpl) : (i_tmpl - i_pixel);
    assign below_ign = {1'b0, i_pixel} < i_ign;
    assign sum_a     = {1'b0, i_tmpl} + {1'b0, i_pixel};
    assign sum_b     = {1'b0, i_tmpl} + {1'b0, sum_a[tpml_pkg::PIX_W:1]};

    always_comb begin
        o_eval = '0;
        case (i_cmd)
            tpml_pkg::CMD_LOAD: begin
                o_eval.wr_en   = i_in_range;
                o_eval.wr_data = i_pixel;
            end
            tpml_pkg::CMD_MATCH: begin
                o_eval.hit = i_in_range && below_ign && ({1'b0, diff} < i_tol);
            end
            tpml_pkg::CMD_LEARN: begin
                o_eval.wr_en   = i_in_range && below_ign;
                o_eval.wr_data = sum_b[tpml_pkg::PIX_W:1];
            end
            default: begin
                o_eval = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_template_pixel_match_and_learn_top.sv @@
`default_nettype none

module tb_template_pixel_match_and_learn_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_SKIP = 2'd3;
    localparam int QUIET_LIMIT = 3000;

    typedef enum {PASS_LOAD, PASS_MATCH, PASS_LEARN, PASS_MIXED} t_pass_kind;

    typedef struct packed {
        logic [tpml_pkg::CNT_W-1:0] count;
        logic                       size_err;
    } t_tally;

    // Predicts the per-frame match tally and size error.
    class t_frame_tally;
        logic [tpml_pkg::PIX_W-1:0] tmpl [tpml_pkg::MAX_PIXELS];
        int unsigned                pos;
        int unsigned                run;
        bit                         ovf;
        int unsigned                pixel_count;
        int unsigned                tol;
        int unsigned                ignore_lvl;
        t_tally                     due [$];
        int unsigned                faults;

        function new();
            pos         = 0;
            run         = 0;
            ovf         = 1'b0;
            pixel_count = tpml_pkg::RST_PIXEL_COUNT;
            tol         = tpml_pkg::RST_MATCH_TOL;
            ignore_lvl  = tpml_pkg::RST_IGNORE_LVL;
            faults      = 0;
        endfunction

        function void apply_regs(int unsigned pc, int unsigned mt, int unsigned il);
            pixel_count = pc;
            tol         = mt;
            ignore_lvl  = il;
        endfunction

        function void take_pixel(logic [1:0] cmd, logic [tpml_pkg::PIX_W-1:0] px,
                                 logic last);
            int unsigned t;
            int unsigned p;
            int unsigned d;
            int unsigned length;
            p = px;
            if (pos >= tpml_pkg::MAX_PIXELS || pos >= pixel_count) begin
                ovf = 1'b1;
            end else begin
                t = tmpl[pos];
                case (cmd)
                    tpml_pkg::CMD_LOAD: begin
                        tmpl[pos] = px;
                    end
                    tpml_pkg::CMD_MATCH: begin
                        d = (p > t) ? p - t : t - p;
                        if (p < ignore_lvl && d < tol && run < tpml_pkg::COUNT_MAX)
                            run++;
                    end
                    tpml_pkg::CMD_LEARN: begin
                        if (p < ignore_lvl)
                            tmpl[pos] = tpml_pkg::PIX_W'((t + ((t + p) >> 1)) >> 1);
                    end
                    default: ;
                endcase
            end
            length = pos + 1;
            if (pos < tpml_pkg::MAX_PIXELS)
                pos++;
            if (last) begin
                due.push_back('{count: tpml_pkg::CNT_W'(run),
                                size_err: ovf || length != pixel_count});
                pos = 0;
                run = 0;
                ovf = 1'b0;
            end
        endfunction

        function void check_tally(logic [tpml_pkg::CNT_W-1:0] cnt, logic err);
            t_tally want;
            if (due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: match_count %0d size_error %0b", cnt, err);
                return;
            end
            want = due.pop_front();
            if (cnt !== want.count || err !== want.size_err) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: count exp %0d got %0d, size_error exp %0b got %0b",
                             want.count, cnt, want.size_err, err);
            end
        endfunction

        function int pending();
            return due.size();
        endfunction

        function bit clean();
            return faults == 0 && due.size() == 0;
        endfunction
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_cfg_we    = 1'b0;
    logic [tpml_pkg::CFG_IDX_W-1:0]       i_cfg_index = tpml_pkg::REG_PIXEL_COUNT;
    logic [tpml_pkg::CFG_DATA_W-1:0]      i_cfg_data  = '0;
    logic                                 i_valid     = 1'b0;
    logic                                 o_stall;
    logic [1:0]                           i_cmd       = tpml_pkg::CMD_LOAD;
    logic [tpml_pkg::PIX_W-1:0]           i_pixel     = '0;
    logic                                 i_frame_end = 1'b0;
    logic                                 o_valid;
    logic                                 i_stall     = 1'b0;
    logic [tpml_pkg::CNT_W-1:0]           o_match_count;
    logic                                 o_size_error;

    t_frame_tally               tally = new();
    bit                         loaded [tpml_pkg::MAX_PIXELS];
    int                         tx_idle_pct = 0;
    int                         rx_idle_pct = 0;
    int                         quiet = 0;
    logic [tpml_pkg::PIX_W-1:0] corner_px [4] = '{8'h00, 8'hFF, 8'h80, 8'h01};

    template_pixel_match_and_learn_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_pixel       (i_pixel),
        .i_frame_end   (i_frame_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_match_count (o_match_count),
        .o_size_error  (o_size_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // results before inputs: a frame closed at this edge cannot report yet
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                tally.check_tally(o_match_count, o_size_error);
            if (i_valid && !o_stall)
                tally.take_pixel(i_cmd, i_pixel, i_frame_end);
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                quiet = 0;
            else
                quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_pixel(input logic [1:0] cmd, input logic [tpml_pkg::PIX_W-1:0] px,
                              input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_pixel     <= px;
        i_frame_end <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // holds the sender off until every pending result is out
    task automatic settle(input int extra);
        i_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (tally.pending() != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic set_regs(input int unsigned pc, input int unsigned mt,
                            input int unsigned il);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tpml_pkg::REG_PIXEL_COUNT;
        i_cfg_data  <= tpml_pkg::CFG_DATA_W'(pc);
        @(negedge i_clk);
        i_cfg_index <= tpml_pkg::REG_MATCH_TOL;
        i_cfg_data  <= tpml_pkg::CFG_DATA_W'(mt);
        @(negedge i_clk);
        i_cfg_index <= tpml_pkg::REG_IGNORE_LVL;
        i_cfg_data  <= tpml_pkg::CFG_DATA_W'(il);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tally.apply_regs(pc, mt, il);
    endtask

    // unloaded template entries are only ever loaded or skipped
    task automatic send_frame(input int unsigned pc, input int unsigned len,
                              input t_pass_kind kind);
        logic [1:0]                 cmd;
        logic [tpml_pkg::PIX_W-1:0] px;
        for (int unsigned i = 0; i < len; i++) begin
            case (kind)
                PASS_LOAD:  cmd = tpml_pkg::CMD_LOAD;
                PASS_MATCH: cmd = tpml_pkg::CMD_MATCH;
                PASS_LEARN: cmd = tpml_pkg::CMD_LEARN;
                default:    cmd = 2'($urandom_range(3));
            endcase
            if (i < pc && i < tpml_pkg::MAX_PIXELS) begin
                if (!loaded[i] && (cmd == tpml_pkg::CMD_MATCH || cmd == tpml_pkg::CMD_LEARN))
                    cmd = tpml_pkg::CMD_LOAD;
                if (cmd == tpml_pkg::CMD_LOAD)
                    loaded[i] = 1'b1;
            end
            case ($urandom_range(7))
                0:       px = 8'h00;
                1:       px = 8'hFF;
                default: px = tpml_pkg::PIX_W'($urandom_range(255));
            endcase
            send_pixel(cmd, px, i == len - 1);
        end
    endtask

    function automatic int unsigned pick_level();
        if ($urandom_range(3) == 0)
            return 256 * $urandom_range(1);
        return $urandom_range(256);
    endfunction

    initial begin
        int unsigned pc;
        int          len;
        int          sent;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        tx_idle_pct = 29;
        rx_idle_pct = 81;

        set_regs(4, 256, 256);
        for (int i = 0; i < 4; i++) begin
            send_pixel(tpml_pkg::CMD_LOAD, corner_px[i], i == 3);
            loaded[i] = 1'b1;
        end
        for (int i = 0; i < 4; i++)
            send_pixel(tpml_pkg::CMD_MATCH, corner_px[i], i == 3);
        send_pixel(tpml_pkg::CMD_LEARN, 8'hFF, 1'b0);
        send_pixel(tpml_pkg::CMD_LEARN, 8'h00, 1'b0);
        send_pixel(CMD_SKIP, 8'h5A, 1'b0);
        send_pixel(tpml_pkg::CMD_LEARN, 8'hC8, 1'b1);
        // frame too long, then too short
        for (int i = 0; i < 6; i++)
            send_pixel(tpml_pkg::CMD_MATCH, corner_px[i % 4], i == 5);
        for (int i = 0; i < 2; i++)
            send_pixel(tpml_pkg::CMD_MATCH, corner_px[i], i == 1);
        settle(4);
        set_regs(4, 0, 0);
        for (int i = 0; i < 4; i++)
            send_pixel(tpml_pkg::CMD_MATCH, corner_px[i], i == 3);

        for (int seg = 0; seg < 3; seg++) begin
            tx_idle_pct = (seg == 0) ? 29 : (seg == 1) ? 81 : 0;
            rx_idle_pct = (seg == 0) ? 81 : (seg == 1) ? 29 : 0;
            for (int ph = 0; ph < 4; ph++) begin
                settle(4);
                case ($urandom_range(9))
                    0:       pc = 0;
                    1:       pc = 1;
                    2:       pc = $urandom_range(8191, tpml_pkg::MAX_PIXELS + 1);
                    default: pc = $urandom_range(40, 2);
                endcase
                set_regs(pc, pick_level(), pick_level());
                sent = 0;
                while (sent < 36) begin
                    if (pc == 0 || pc > tpml_pkg::MAX_PIXELS) begin
                        len = $urandom_range(8, 1);
                    end else begin
                        len = pc;
                        if ($urandom_range(3) == 0)
                            len = int'(pc) - 1 + int'($urandom_range(3));
                        if (len < 1)
                            len = 1;
                    end
                    if ($urandom_range(7) == 0)
                        settle(0);
                    send_frame(pc, len, t_pass_kind'($urandom_range(3)));
                    sent += len;
                end
            end
        end

        settle(20);
        if (tally.clean())
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
